FILE: hw/rtl/tfn_pkg.sv
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants of the triangle face normal generator.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int VTX_DEPTH = 4096;
  localparam int VTX_AW    = $clog2(VTX_DEPTH);

  // Cross product component width: 25-bit edges, 50-bit products, one sum.
  localparam int XW = 52;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_FACE   = 2'd1;
  localparam logic [1:0] REQ_GATHER = 2'd2;

  localparam logic [1:0] CORNER_A = 2'd0;
  localparam logic [1:0] CORNER_B = 2'd1;
  localparam logic [1:0] CORNER_C = 2'd2;

  localparam logic [15:0] UNIT_ONE = 16'd16384;
  localparam logic signed [24:0] SAT_HI = 25'sd8388607;
  localparam logic signed [24:0] SAT_LO = -25'sd8388608;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } vec24_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
  } xvec_t;

endpackage

FILE: hw/rtl/tfn_cross.sv
// ----------------------------------------------------------------------------
// tfn_cross
// Edge vectors and their cross product over one shared multiplier, six products in turn.
// ----------------------------------------------------------------------------
module tfn_cross import tfn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  vec24_t pa,
  input  vec24_t pb,
  input  vec24_t pc,
  output logic   done,
  output xvec_t  xv
);

  logic signed [24:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [24:0] op_a, op_b;
  logic signed [49:0] prod_r;
  logic [2:0]         cnt_r;
  logic               run_r;
  logic               done_r;
  xvec_t              xv_r;
  logic [2:0]         term;
  logic signed [XW-1:0] prod_x;

  always_comb begin
    case (cnt_r)
      3'd0: begin op_a = e1y_r; op_b = e2z_r; end
      3'd1: begin op_a = e1z_r; op_b = e2y_r; end
      3'd2: begin op_a = e1z_r; op_b = e2x_r; end
      3'd3: begin op_a = e1x_r; op_b = e2z_r; end
      3'd4: begin op_a = e1x_r; op_b = e2y_r; end
      3'd5: begin op_a = e1y_r; op_b = e2x_r; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign term   = cnt_r - 3'd1;
  assign prod_x = XW'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        e1x_r <= 25'(pa.x) - 25'(pb.x);
        e1y_r <= 25'(pa.y) - 25'(pb.y);
        e1z_r <= 25'(pa.z) - 25'(pb.z);
        e2x_r <= 25'(pb.x) - 25'(pc.x);
        e2y_r <= 25'(pb.y) - 25'(pc.y);
        e2z_r <= 25'(pb.z) - 25'(pc.z);
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        prod_r <= op_a * op_b;
        // accumulate the registered product of the previous step
        if (cnt_r != 3'd0) begin
          case (term)
            3'd0: xv_r.x <= prod_x;
            3'd1: xv_r.x <= xv_r.x - prod_x;
            3'd2: xv_r.y <= prod_x;
            3'd3: xv_r.y <= xv_r.y - prod_x;
            3'd4: xv_r.z <= prod_x;
            3'd5: xv_r.z <= xv_r.z - prod_x;
            default: ;
          endcase
        end
        if (cnt_r == 3'd6) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign xv   = xv_r;

endmodule

FILE: hw/rtl/tfn_unit.sv
// ----------------------------------------------------------------------------
// tfn_unit
// Unit vector in Q1.14: scale, sum of squares, bit-serial square root and
// restoring division, one step per cycle.
// ----------------------------------------------------------------------------
module tfn_unit import tfn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  xvec_t  xv,
  output logic   done,
  output vec24_t nv
);

  typedef enum logic [2:0] {
    U_IDLE, U_ABS, U_SCALE, U_SQ, U_SQRT, U_DSET, U_DIV, U_STORE
  } ustate_t;

  ustate_t     state_r;
  logic [XW-1:0] u_r [3];
  logic [2:0]  neg_r;
  logic [4:0]  cnt_r;
  logic [1:0]  i_r;
  logic [59:0] prod_r;
  logic [63:0] s_r, res_r, bit_r;
  logic [47:0] rem_r, dv_r;
  logic [15:0] q_r;
  logic        done_r;
  vec24_t      nv_r;
  logic [XW-1:0] m;
  logic [63:0] trial;
  logic [15:0] q_sat;
  logic signed [23:0] q_s;

  always_comb begin
    m = u_r[0];
    if (u_r[1] > m) m = u_r[1];
    if (u_r[2] > m) m = u_r[2];
  end

  assign trial = res_r + bit_r;
  assign q_sat = (q_r > UNIT_ONE) ? UNIT_ONE : q_r;
  assign q_s   = neg_r[i_r] ? -24'(q_sat) : 24'(q_sat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        U_IDLE: begin
          if (start) begin
            neg_r <= {xv.z[XW-1], xv.y[XW-1], xv.x[XW-1]};
            u_r[0] <= xv.x[XW-1] ? -xv.x : xv.x;
            u_r[1] <= xv.y[XW-1] ? -xv.y : xv.y;
            u_r[2] <= xv.z[XW-1] ? -xv.z : xv.z;
            state_r <= U_ABS;
          end
        end
        U_ABS: begin
          if (m == '0) begin
            nv_r    <= '0;
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end else begin
            state_r <= U_SCALE;
          end
        end
        U_SCALE: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (m[XW-1:30] != '0) begin
            for (int k = 0; k < 3; k++) u_r[k] <= u_r[k] >> 1;
          end else if (!m[29]) begin
            for (int k = 0; k < 3; k++) u_r[k] <= u_r[k] << 1;
          end else begin
            cnt_r   <= '0;
            s_r     <= '0;
            state_r <= U_SQ;
          end
        end
        U_SQ: begin
          if (cnt_r < 5'd3) prod_r <= u_r[cnt_r[1:0]][29:0] * u_r[cnt_r[1:0]][29:0];
          if (cnt_r != 5'd0) s_r <= s_r + 64'(prod_r);
          if (cnt_r == 5'd3) begin
            res_r   <= '0;
            bit_r   <= 64'd1 << 62;
            cnt_r   <= '0;
            state_r <= U_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        U_SQRT: begin
          if (s_r >= trial) begin
            s_r   <= s_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            i_r     <= '0;
            state_r <= U_DSET;
          end
        end
        U_DSET: begin
          rem_r   <= (48'(u_r[i_r][29:0]) << 15) + 48'(res_r[31:0]);
          dv_r    <= 48'(res_r[31:0]) << 16;
          q_r     <= '0;
          cnt_r   <= 5'd15;
          state_r <= U_DIV;
        end
        U_DIV: begin
          if (rem_r >= dv_r) begin
            rem_r         <= rem_r - dv_r;
            q_r[cnt_r[3:0]] <= 1'b1;
          end
          dv_r <= dv_r >> 1;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) state_r <= U_STORE;
        end
        U_STORE: begin
          case (i_r)
            2'd0: nv_r.x <= q_s;
            2'd1: nv_r.y <= q_s;
            default: nv_r.z <= q_s;
          endcase
          if (i_r == 2'd2) begin
            done_r  <= 1'b1;
            state_r <= U_IDLE;
          end else begin
            i_r     <= i_r + 2'd1;
            state_r <= U_DSET;
          end
        end
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign nv   = nv_r;

endmodule

FILE: hw/rtl/triangle_face_normal_generator.sv
// ----------------------------------------------------------------------------
// triangle_face_normal_generator
// Vertex position store, per-vertex normal accumulators and face normals.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       start / busy           req_type, vertex_index, pos_xyz, corner_abc
//  out      out_valid (one cycle)  norm_xyz, corner, last
//  cfg      cfg_valid / cfg_ready  smooth_mode
//
//  A load is written without raising busy. A gather keeps busy high while it
//  reads and emits each corner in turn. A face keeps busy high through the
//  position reads of the three corners, 6 multiplier steps, a one-bit-a-cycle
//  scaling shift, 32 square root steps and a restoring divide per component,
//  then one emit per corner in flat mode or an accumulator read-modify-write
//  per corner in smooth mode. A degenerate face gets a zero normal instead.
//  After reset busy stays high while the accumulators clear.
//  Results cannot be stalled; busy holds off the next item.
// ----------------------------------------------------------------------------
module triangle_face_normal_generator import tfn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_req_type,
  input  logic [11:0]        in_vertex_index,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic [11:0]        in_corner_a,
  input  logic [11:0]        in_corner_b,
  input  logic [11:0]        in_corner_c,
  output logic               out_valid,
  output logic signed [23:0] out_norm_x,
  output logic signed [23:0] out_norm_y,
  output logic signed [23:0] out_norm_z,
  output logic [1:0]         out_corner,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_smooth_mode
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RA, S_RB, S_RC, S_RW, S_XS, S_CROSS, S_UNIT,
    S_EMIT, S_ACC_RD, S_ACC_WR, S_G_RD, S_G_EM
  } state_t;

  state_t      state_r;
  logic [VTX_AW-1:0] clr_r;
  logic [VTX_AW-1:0] ca_r, cb_r, cc_r, kaddr, pos_ra, acc_addr;
  logic [1:0]  k_r;
  logic        smooth_r;
  vec24_t      pa_r, pb_r, pc_r, nv_r;
  vec24_t      pos_mem [VTX_DEPTH];
  vec24_t      acc_mem [VTX_DEPTH];
  vec24_t      pos_q_r, acc_q_r, acc_wd;
  logic        pos_we, acc_we, accept;
  logic        cross_start, cross_done, unit_start, unit_done;
  xvec_t       xv;
  vec24_t      unit_n;
  logic        out_valid_r, out_last_r;
  logic [1:0]  out_corner_r;
  vec24_t      out_n_r;

  function automatic logic signed [23:0] sat_add(logic signed [23:0] a,
                                                 logic signed [23:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > SAT_HI) return SAT_HI[23:0];
    if (s < SAT_LO) return SAT_LO[23:0];
    return s[23:0];
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (k_r)
      CORNER_A: kaddr = ca_r;
      CORNER_B: kaddr = cb_r;
      default:  kaddr = cc_r;
    endcase
    case (state_r)
      S_RB:    pos_ra = cb_r;
      S_RC:    pos_ra = cc_r;
      default: pos_ra = ca_r;
    endcase
  end

  assign pos_we   = accept && (in_req_type == REQ_LOAD);
  assign acc_we   = (state_r == S_CLR) || (state_r == S_ACC_WR);
  assign acc_addr = (state_r == S_CLR) ? clr_r : kaddr;
  assign acc_wd   = (state_r == S_CLR) ? '0 :
                    vec24_t'{sat_add(acc_q_r.x, nv_r.x), sat_add(acc_q_r.y, nv_r.y),
                             sat_add(acc_q_r.z, nv_r.z)};

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[in_vertex_index] <= '{in_pos_x, in_pos_y, in_pos_z};
    pos_q_r <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_addr] <= acc_wd;
    acc_q_r <= acc_mem[acc_addr];
  end

  assign cross_start = (state_r == S_XS);
  assign unit_start  = (state_r == S_CROSS) && cross_done;

  tfn_cross u_cross (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cross_start),
    .pa    (pa_r),
    .pb    (pb_r),
    .pc    (pc_r),
    .done  (cross_done),
    .xv    (xv)
  );

  tfn_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .xv    (xv),
    .done  (unit_done),
    .nv    (unit_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      smooth_r    <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) smooth_r <= cfg_smooth_mode;
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == VTX_AW'(VTX_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            ca_r <= in_corner_a;
            cb_r <= in_corner_b;
            cc_r <= in_corner_c;
            k_r  <= CORNER_A;
            case (in_req_type)
              REQ_FACE:   state_r <= S_RA;
              REQ_GATHER: state_r <= S_G_RD;
              default:    state_r <= S_IDLE;
            endcase
          end
        end
        S_RA: state_r <= S_RB;
        S_RB: begin
          pa_r    <= pos_q_r;
          state_r <= S_RC;
        end
        S_RC: begin
          pb_r    <= pos_q_r;
          state_r <= S_RW;
        end
        S_RW: begin
          pc_r    <= pos_q_r;
          state_r <= S_XS;
        end
        S_XS: state_r <= S_CROSS;
        S_CROSS: begin
          if (cross_done) state_r <= S_UNIT;
        end
        S_UNIT: begin
          if (unit_done) begin
            nv_r    <= unit_n;
            state_r <= smooth_r ? S_ACC_RD : S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid_r  <= 1'b1;
          out_n_r      <= nv_r;
          out_corner_r <= k_r;
          out_last_r   <= (k_r == CORNER_C);
          k_r          <= k_r + 2'd1;
          if (k_r == CORNER_C) state_r <= S_IDLE;
        end
        // one corner at a time: the write lands before the next read
        S_ACC_RD: state_r <= S_ACC_WR;
        S_ACC_WR: begin
          k_r     <= k_r + 2'd1;
          state_r <= (k_r == CORNER_C) ? S_IDLE : S_ACC_RD;
        end
        S_G_RD: state_r <= S_G_EM;
        S_G_EM: begin
          out_valid_r  <= 1'b1;
          out_n_r      <= acc_q_r;
          out_corner_r <= k_r;
          out_last_r   <= (k_r == CORNER_C);
          k_r          <= k_r + 2'd1;
          state_r      <= (k_r == CORNER_C) ? S_IDLE : S_G_RD;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_norm_x = out_n_r.x;
  assign out_norm_y = out_n_r.y;
  assign out_norm_z = out_n_r.z;
  assign out_corner = out_corner_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_corner == CORNER_C)))
    else $error("last does not match corner");
  a_corner_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |=> (!out_valid || (out_corner != CORNER_A)))
    else $error("corner sequence restarted mid face");
`endif

endmodule
